[rtl/core/pfx_pkg.sv]
// ----------------------------------------------------------------------------
// pfx_pkg
// Shared types and constants of the piecewise polynomial evaluator.
// ----------------------------------------------------------------------------
package pfx_pkg;

  localparam int WORD_W         = 64;
  localparam int FRAC_W         = 6;
  localparam int CNT_W          = 3;
  localparam int SLOT_W         = 5;
  localparam int MAX_THRESHOLDS = 4;
  localparam int MAX_TERMS      = 4;
  localparam int REGION_COUNT   = MAX_THRESHOLDS + 1;
  localparam int COEF_DEPTH     = REGION_COUNT * MAX_TERMS;
  localparam int REGION_W       = $clog2(REGION_COUNT);
  localparam int TERM_W         = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int THR_IDX_W      = (MAX_THRESHOLDS > 1) ? $clog2(MAX_THRESHOLDS) : 1;
  localparam int COEF_IDX_W     = $clog2(COEF_DEPTH);
  localparam int PADDR_W        = 4;
  localparam int PDATA_W        = 32;

  localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(16);
  localparam logic [CNT_W-1:0]  TCNT_RESET = CNT_W'(1);
  localparam logic [CNT_W-1:0]  NCNT_RESET = CNT_W'(2);

  typedef enum logic [1:0] {
    ACT_THR  = 2'd0,
    ACT_COEF = 2'd1,
    ACT_EVAL = 2'd2,
    ACT_NONE = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    REG_FRAC = 2'd0,
    REG_TCNT = 2'd1,
    REG_NCNT = 2'd2,
    REG_NONE = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLAG,
    ST_COEF,
    ST_WAITC,
    ST_POW,
    ST_WAITP,
    ST_OUT
  } state_t;

  typedef struct packed {
    act_t                    kind;
    logic [SLOT_W-1:0]       slot;
    logic signed [WORD_W-1:0] operand;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic [FRAC_W-1:0]   frac;
    logic [REGION_W-1:0] nt;
    logic [CNT_W-1:0]    nc;
  } cfg_t;

  typedef struct packed {
    logic pop;
    logic emit;
  } back_stat_t;

endpackage

[rtl/core/pfx_front.sv]
// ----------------------------------------------------------------------------
// pfx_front
// Accepts input transactions, classifies them, drops ignored ones and queues
// the rest in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module pfx_front import pfx_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_action,
  input  logic [SLOT_W-1:0]        in_slot,
  input  logic signed [WORD_W-1:0] in_operand,
  output queue_head_t              head,
  input  logic                     pop
);

  item_t      q_r [2];
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       keep;
  logic       push;
  item_t      cls;

  always_comb begin
    cls.kind    = act_t'(in_action);
    cls.slot    = in_slot;
    cls.operand = in_operand;
    case (cls.kind)
      ACT_THR:  keep = (in_slot < SLOT_W'(MAX_THRESHOLDS));
      ACT_COEF: keep = (in_slot < SLOT_W'(COEF_DEPTH));
      ACT_EVAL: keep = 1'b1;
      default:  keep = 1'b0;
    endcase
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready && keep;

  assign head.valid = (count_r != 2'd0);
  assign head.item  = q_r[rd_ptr_r];

  always_comb begin
    rd_ptr_nxt = rd_ptr_r ^ pop;
    wr_ptr_nxt = wr_ptr_r ^ push;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

[rtl/core/pfx_mul.sv]
// ----------------------------------------------------------------------------
// pfx_mul
// Iterative signed fixed-point multiplier: four 32x32 partial products, a
// sign correction, then an arithmetic shift by the fraction bits.
// ----------------------------------------------------------------------------
module pfx_mul import pfx_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [WORD_W-1:0]        a,
  input  logic [WORD_W-1:0]        b,
  input  logic [FRAC_W-1:0]        sh,
  output logic                     done,
  output logic [WORD_W-1:0]        y
);

  localparam int HALF = WORD_W / 2;

  logic [2:0]          step_r, step_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [WORD_W-1:0]   a_r, b_r, y_r;
  logic [FRAC_W-1:0]   sh_r;
  logic [2*WORD_W-1:0] prod_r;
  logic [HALF-1:0]     pa, pb;
  logic [WORD_W-1:0]   pp;
  logic [2*WORD_W-1:0] pp_sh;
  logic [WORD_W-1:0]   corr;
  logic [2*WORD_W-1:0] shifted;

  always_comb begin
    pa    = step_r[1] ? a_r[WORD_W-1:HALF] : a_r[HALF-1:0];
    pb    = step_r[0] ? b_r[WORD_W-1:HALF] : b_r[HALF-1:0];
    pp    = WORD_W'(pa) * WORD_W'(pb);
    pp_sh = (2*WORD_W)'(pp) << (HALF * (32'(step_r[1]) + 32'(step_r[0])));
    corr  = (a_r[WORD_W-1] ? b_r : '0) + (b_r[WORD_W-1] ? a_r : '0);
    shifted = prod_r >> sh_r;
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        step_nxt = 3'd0;
      end
    end else begin
      step_nxt = step_r + 3'd1;
      if (step_r == 3'd5) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 3'd0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      a_r    <= a;
      b_r    <= b;
      sh_r   <= sh;
      prod_r <= '0;
    end else if (busy_r) begin
      if (step_r < 3'd4) begin
        prod_r <= prod_r + pp_sh;
      end else if (step_r == 3'd4) begin
        prod_r[2*WORD_W-1:WORD_W] <= prod_r[2*WORD_W-1:WORD_W] - corr;
      end else begin
        y_r <= shifted[WORD_W-1:0];
      end
    end
  end

  assign done = done_r;
  assign y    = y_r;

endmodule

[rtl/core/pfx_back.sv]
// ----------------------------------------------------------------------------
// pfx_back
// Owns the threshold and coefficient tables, applies loads and runs each
// evaluation through the shared multiplier, then holds the result register.
// ----------------------------------------------------------------------------
module pfx_back import pfx_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  queue_head_t              head,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] out_result,
  output back_stat_t               stat
);

  state_t                state_r, state_nxt;
  logic [WORD_W-1:0]     thr_r  [MAX_THRESHOLDS];
  logic [WORD_W-1:0]     coef_r [COEF_DEPTH];
  logic [WORD_W-1:0]     x_r, power_r, acc_r, res_r;
  logic [REGION_COUNT-1:0] flag_r, flag_nxt;
  logic [REGION_W-1:0]   r_r;
  logic [CNT_W-1:0]      c_r;
  logic                  out_valid_r;
  logic [MAX_THRESHOLDS-1:0] below;
  logic [REGION_COUNT-1:0] below_x;
  logic [COEF_IDX_W-1:0] caddr;
  logic                  last_r, last_c, out_free;
  logic                  mul_start, mul_done;
  logic [WORD_W-1:0]     mul_a, mul_b, mul_y;
  logic                  wr_thr, wr_coef, emit;

  pfx_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .sh    (cfg.frac),
    .done  (mul_done),
    .y     (mul_y)
  );

  assign caddr    = COEF_IDX_W'(r_r) * COEF_IDX_W'(MAX_TERMS) + COEF_IDX_W'(c_r);
  assign last_r   = (r_r == cfg.nt);
  assign last_c   = (c_r == cfg.nc - CNT_W'(1));
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    for (int t = 0; t < MAX_THRESHOLDS; t++) begin
      below[t] = $signed(x_r) < $signed(thr_r[t]);
    end
    below_x = {1'b0, below};
    flag_nxt = '0;
    flag_nxt[0] = below[0];
    for (int r = 1; r < REGION_COUNT; r++) begin
      if (REGION_W'(r) == cfg.nt) begin
        flag_nxt[r] = !below_x[r-1];
      end else if (REGION_W'(r) < cfg.nt) begin
        flag_nxt[r] = !below_x[r-1] && below_x[r];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (head.valid && head.item.kind == ACT_EVAL) begin
          state_nxt = ST_FLAG;
        end
      end
      ST_FLAG: begin
        state_nxt = (cfg.nc == '0) ? ST_OUT : ST_COEF;
      end
      ST_COEF: begin
        if (flag_r[r_r]) begin
          state_nxt = ST_WAITC;
        end else if (last_r) begin
          state_nxt = last_c ? ST_OUT : ST_POW;
        end
      end
      ST_WAITC: begin
        if (mul_done) begin
          if (last_r) begin
            state_nxt = last_c ? ST_OUT : ST_POW;
          end else begin
            state_nxt = ST_COEF;
          end
        end
      end
      ST_POW:   state_nxt = ST_WAITP;
      ST_WAITP: begin
        if (mul_done) begin
          state_nxt = ST_COEF;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    wr_thr    = 1'b0;
    wr_coef   = 1'b0;
    mul_start = 1'b0;
    mul_a     = coef_r[caddr];
    mul_b     = power_r;
    emit      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop     = 1'b1;
          wr_thr  = (head.item.kind == ACT_THR);
          wr_coef = (head.item.kind == ACT_COEF);
        end
      end
      ST_COEF: mul_start = flag_r[r_r];
      ST_POW: begin
        mul_start = 1'b1;
        mul_a     = x_r;
      end
      ST_OUT:  emit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_thr) begin
      thr_r[head.item.slot[THR_IDX_W-1:0]] <= head.item.operand;
    end
    if (wr_coef) begin
      coef_r[head.item.slot[COEF_IDX_W-1:0]] <= head.item.operand;
    end
    case (state_r)
      ST_IDLE: begin
        x_r <= head.item.operand;
      end
      ST_FLAG: begin
        flag_r  <= flag_nxt;
        acc_r   <= '0;
        power_r <= WORD_W'(1) << cfg.frac;
        r_r     <= '0;
        c_r     <= '0;
      end
      ST_COEF: begin
        if (!flag_r[r_r] && !last_r) begin
          r_r <= r_r + REGION_W'(1);
        end
      end
      ST_WAITC: begin
        if (mul_done) begin
          acc_r <= acc_r + mul_y;
          if (!last_r) begin
            r_r <= r_r + REGION_W'(1);
          end
        end
      end
      ST_WAITP: begin
        if (mul_done) begin
          power_r <= mul_y;
          c_r     <= c_r + CNT_W'(1);
          r_r     <= '0;
        end
      end
      default: ;
    endcase
    if (emit) begin
      res_r <= acc_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = res_r;
  assign stat.pop   = pop;
  assign stat.emit  = emit;

endmodule

[rtl/core/piecewise_polynomial_fixed_point.sv]
// ----------------------------------------------------------------------------
// piecewise_polynomial_fixed_point
// Piecewise polynomial evaluator on signed 64-bit fixed-point samples.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): action 0 loads a threshold, action 1 a
// coefficient, action 2 evaluates the sample in in_operand; action 3 and
// out-of-range slots are dropped. Loads produce no result.
// Result channel (out_valid/out_ready) carries one out_result per evaluation.
// A two-entry queue separates intake from execution, so intake continues
// while a result waits. The back end applies a load as it leaves the queue.
// An evaluation issues its multiplies one at a time through the shared
// multiplier; with term_count 0 it issues none and its result is zero.
// Registers on the APB port: frac_bits at 0x0, threshold_count at 0x4,
// term_count at 0x8; pready is always high. Write only while idle.
// Reset clears control state and sets the registers to 16, 1, 2; the tables
// are undefined until written. When out_ready is low the result holds and
// the back end waits before delivering the next one.
// ----------------------------------------------------------------------------
module piecewise_polynomial_fixed_point import pfx_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_action,
  input  logic [SLOT_W-1:0]        in_slot,
  input  logic signed [WORD_W-1:0] in_operand,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] out_result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  logic [FRAC_W-1:0] frac_r;
  logic [CNT_W-1:0]  tcnt_r, ncnt_r;
  reg_idx_t          idx;
  cfg_t              cfg;
  queue_head_t       head;
  logic              pop;
  back_stat_t        stat;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r <= FRAC_RESET;
      tcnt_r <= TCNT_RESET;
      ncnt_r <= NCNT_RESET;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_FRAC: frac_r <= pwdata[FRAC_W-1:0];
        REG_TCNT: tcnt_r <= pwdata[CNT_W-1:0];
        REG_NCNT: ncnt_r <= pwdata[CNT_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRAC: prdata = PDATA_W'(frac_r);
      REG_TCNT: prdata = PDATA_W'(tcnt_r);
      REG_NCNT: prdata = PDATA_W'(ncnt_r);
      default:  prdata = '0;
    endcase
    cfg.frac = frac_r;
    if (tcnt_r == '0) begin
      cfg.nt = REGION_W'(1);
    end else if (tcnt_r > CNT_W'(MAX_THRESHOLDS)) begin
      cfg.nt = REGION_W'(MAX_THRESHOLDS);
    end else begin
      cfg.nt = REGION_W'(tcnt_r);
    end
    cfg.nc = (ncnt_r > CNT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : ncnt_r;
  end

  pfx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_action  (in_action),
    .in_slot    (in_slot),
    .in_operand (in_operand),
    .head       (head),
    .pop        (pop)
  );

  pfx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result),
    .stat       (stat)
  );

`ifndef SYNTH
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pop |-> head.valid) else $error("pop from empty queue");
  a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(stat.emit)) else $error("result without emit");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    stat.emit |-> (!out_valid || out_ready)) else $error("result overwritten");
`endif

endmodule
